### rtl/core/lsfs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the LED sparkle-fade sequencer.
// No dependencies.
package lsfs_pkg;

   localparam int MaxLeds = 64;
   localparam int LedIdxW = $clog2(MaxLeds);
   localparam int LedCntW = LedIdxW + 1;
   localparam int FrameW = 10;
   localparam int TimerW = 17;
   localparam int MsW = 16;
   localparam int SpanW = 15;
   localparam int ProdW = 24;
   localparam int QuotW = 8;
   localparam int BProdW = 15;
   localparam int RecipW = 13;
   localparam int RecipShift = 19;

   localparam logic [TimerW-1:0] TimerMax = '1;
   localparam logic [31:0] LfsrMask = 32'h8020_0003;
   localparam logic [RecipW-1:0] RecipMul = 13'd5243;  // x/100 == (x*5243)>>19 for x < 43690
   localparam logic [6:0] PctFull = 7'd100;

   typedef enum logic [2:0] {
      REG_OFF_TIME,
      REG_FADE_IN,
      REG_FADE_OUT,
      REG_BRIGHTNESS,
      REG_USER_COLOR,
      REG_RANDOM_EN,
      REG_ACTIVE_LEDS,
      REG_SEED
   } reg_idx_type;

   // Channel 0 is red (bits 7:0), 1 green, 2 blue.
   typedef logic [2:0][7:0] rgb_type;
   typedef logic [2:0][ProdW-1:0] prod3_type;

   typedef struct packed {
      logic [MsW-1:0] off_time;
      logic [MsW-1:0] fade_in;
      logic [MsW-1:0] fade_out;
      logic [6:0] bright;               // already limited to 100
      rgb_type user_color;
      logic random_en;
      logic [LedCntW-1:0] led_count;    // already limited to 1..MaxLeds
   } cfg_type;

   function automatic logic [31:0] lfsr_step(input logic [31:0] s);
      logic [31:0] r;
      r = s >> 1;
      if (s[0]) begin
         r = r ^ LfsrMask;
      end
      return r;
   endfunction

endpackage

### rtl/core/lsfs_front.sv
`timescale 1ns / 1ps
// Front end: accepts frame ticks and holds them in a two-entry queue.
// Depends on lsfs_pkg.
module lsfs_front import lsfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [FrameW-1:0] req_frame_ms,
   output logic              q_valid,
   output logic [FrameW-1:0] q_frame_ms,
   input  logic              q_pop
);

   logic [FrameW-1:0] slot_ff [2];
   logic wr_ptr_ff;
   logic rd_ptr_ff;
   logic [1:0] count_ff;
   logic push;
   logic pop;

   assign req_stall = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_frame_ms = slot_ff[rd_ptr_ff];
   assign push = req_valid && !req_stall;
   assign pop = q_pop && q_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_frame_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

### rtl/core/lsfs_div.sv
`timescale 1ns / 1ps
// Three-lane restoring divider, one quotient bit per lane per cycle.
// Quotient is known to fit 8 bits. Depends on lsfs_pkg.
module lsfs_div import lsfs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  prod3_type      dividend,
   input  logic [MsW-1:0] divisor,
   output logic           done,
   output rgb_type        quot
);

   logic [2:0][MsW-1:0] rem_ff, rem_in;
   logic [2:0][QuotW-1:0] low_ff, low_in;
   logic [MsW-1:0] den_ff;
   logic busy_ff;
   logic done_ff;
   logic [$clog2(QuotW)-1:0] step_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [MsW:0] trial;
         logic ge;
         trial = {rem_ff[k], low_ff[k][QuotW-1]};
         ge = (trial >= {1'b0, den_ff});
         rem_in[k] = ge ? MsW'(trial - {1'b0, den_ff}) : trial[MsW-1:0];
         low_in[k] = {low_ff[k][QuotW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= divisor;
         for (int k = 0; k < 3; k++) begin
            rem_ff[k] <= dividend[k][ProdW-1:QuotW];
            low_ff[k] <= dividend[k][QuotW-1:0];
         end
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == '1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         quot[k] = low_ff[k];
      end
   end

endmodule

### rtl/core/lsfs_back.sv
`timescale 1ns / 1ps
// Back end: phase sequencer, per-LED timing and colour stores, result register.
// Depends on lsfs_pkg and lsfs_div.
module lsfs_back import lsfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic [31:0]        seed,
   input  logic               seed_load,
   input  logic               q_valid,
   input  logic [FrameW-1:0]  q_frame_ms,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [LedIdxW-1:0] rsp_led_index,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic               rsp_last_led
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_BMUL, ST_BRECIP, ST_SMUL, ST_SDIV,
      ST_READ, ST_EVAL, ST_ON2, ST_ON3, ST_EMIT, ST_FINISH
   } state_type;

   typedef enum logic [1:0] {PH_OFF, PH_FADEIN, PH_ON, PH_FADEOUT} phase_type;
   typedef enum logic [1:0] {ACT_KEEP, ACT_FADEIN, ACT_ON, ACT_FADEOUT} act_type;

   state_type state_ff;
   phase_type phase_ff;
   act_type act_ff;
   logic [TimerW-1:0] timer_ff;
   rgb_type color_ff;
   logic [31:0] lfsr_ff;
   logic [2:0][BProdW-1:0] bprod_ff;
   rgb_type sc_ff;
   logic [MsW-1:0] num_ff;
   logic [MsW-1:0] den_ff;
   rgb_type fadec_ff;
   rgb_type newc_ff;
   logic [LedIdxW-1:0] idx_ff;
   logic all_dark_ff;
   logic [SpanW-1:0] dly_ff;

   logic rsp_valid_ff;
   logic [LedIdxW-1:0] rsp_idx_ff;
   rgb_type rsp_col_ff;
   logic rsp_last_ff;

   // per-LED stores
   logic [SpanW-1:0] dly_mem [MaxLeds];
   logic [SpanW-1:0] per_mem [MaxLeds];
   rgb_type col_mem [MaxLeds];
   logic [MaxLeds-1:0] col_vld_ff;
   logic [SpanW-1:0] rd_dly_ff;
   logic [SpanW-1:0] rd_per_ff;
   rgb_type rd_col_ff;
   logic rd_vld_ff;

   logic col_we;
   rgb_type col_wd;
   logic span_we;
   logic [SpanW-1:0] span_now;
   logic [31:0] lfsr_next;
   logic [TimerW:0] timer_sum;
   logic [TimerW-1:0] elapsed;
   logic fo_wait;
   logic fo_dark;
   logic is_last;
   logic emit_load;
   rgb_type keep_col;
   prod3_type div_dividend;
   logic div_start;
   logic div_done;
   rgb_type div_quot;
   logic [2*32-1:0] span_prod;

   assign lfsr_next = lfsr_step(lfsr_ff);
   assign span_prod = 64'(lfsr_ff) * 64'(cfg.fade_out);
   assign span_now = span_prod[33 +: SpanW];
   assign timer_sum = {1'b0, timer_ff} + (TimerW + 1)'(q_frame_ms);
   assign elapsed = timer_ff - TimerW'(rd_dly_ff);
   assign fo_wait = (timer_ff < TimerW'(rd_dly_ff));
   assign fo_dark = !fo_wait && ((rd_per_ff == '0) || (elapsed > TimerW'(rd_per_ff)));
   assign is_last = ({1'b0, idx_ff} == cfg.led_count - 1'b1);
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign keep_col = rd_vld_ff ? rd_col_ff : '0;
   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         div_dividend[k] = ProdW'(sc_ff[k] * num_ff);
      end
   end
   assign div_start = (state_ff == ST_SMUL);

   lsfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (den_ff),
      .done     (div_done),
      .quot     (div_quot)
   );

   always_comb begin
      col_we = 1'b0;
      col_wd = div_quot;
      span_we = (state_ff == ST_ON3);
      priority if (state_ff == ST_EVAL && act_ff == ACT_FADEIN) begin
         col_we = 1'b1;
         col_wd = fadec_ff;
      end else if (state_ff == ST_EVAL && act_ff == ACT_FADEOUT && fo_dark) begin
         col_we = 1'b1;
         col_wd = '0;
      end else if (state_ff == ST_ON3) begin
         col_we = 1'b1;
         col_wd = color_ff;
      end else if (state_ff == ST_SDIV && div_done && act_ff == ACT_FADEOUT) begin
         col_we = 1'b1;
         col_wd = div_quot;
      end else begin
         col_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[idx_ff] <= col_wd;
      end
      if (span_we) begin
         dly_mem[idx_ff] <= dly_ff;
         per_mem[idx_ff] <= span_now;
      end
      rd_col_ff <= col_mem[idx_ff];
      rd_dly_ff <= dly_mem[idx_ff];
      rd_per_ff <= per_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_vld_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= col_vld_ff[idx_ff];
         if (col_we) begin
            col_vld_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_OFF;
         act_ff <= ACT_KEEP;
         timer_ff <= '0;
         color_ff <= '0;
         lfsr_ff <= 32'd1;
         idx_ff <= '0;
         all_dark_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (seed_load) begin
            lfsr_ff <= (seed == '0) ? 32'd1 : seed;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  timer_ff <= timer_sum[TimerW] ? TimerMax : timer_sum[TimerW-1:0];
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               unique case (phase_ff)
                  PH_OFF: begin
                     act_ff <= ACT_KEEP;
                     if (timer_ff > TimerW'(cfg.off_time)) begin
                        phase_ff <= PH_FADEIN;
                        timer_ff <= '0;
                        if (cfg.random_en) begin
                           color_ff <= lfsr_next[23:0];
                           lfsr_ff <= lfsr_next;
                        end else begin
                           color_ff <= cfg.user_color;
                        end
                     end
                  end
                  PH_FADEIN: begin
                     if (timer_ff > TimerW'(cfg.fade_in)) begin
                        phase_ff <= PH_ON;
                        act_ff <= ACT_KEEP;
                     end else begin
                        act_ff <= ACT_FADEIN;
                     end
                  end
                  PH_ON: begin
                     act_ff <= ACT_ON;
                     phase_ff <= PH_FADEOUT;
                     timer_ff <= '0;
                  end
                  PH_FADEOUT: begin
                     act_ff <= ACT_FADEOUT;
                     all_dark_ff <= 1'b1;
                  end
                  default: ;
               endcase
               state_ff <= ST_BMUL;
            end
            ST_BMUL: begin
               for (int k = 0; k < 3; k++) begin
                  bprod_ff[k] <= BProdW'(color_ff[k] * cfg.bright);
               end
               state_ff <= ST_BRECIP;
            end
            ST_BRECIP: begin
               for (int k = 0; k < 3; k++) begin
                  sc_ff[k] <= 8'((28'(bprod_ff[k]) * 28'(RecipMul)) >> RecipShift);
               end
               idx_ff <= '0;
               if (act_ff == ACT_FADEIN) begin
                  // fade-in length zero is only reached at timer 0: full colour
                  num_ff <= (cfg.fade_in == '0) ? MsW'(1) : timer_ff[MsW-1:0];
                  den_ff <= (cfg.fade_in == '0) ? MsW'(1) : cfg.fade_in;
                  state_ff <= ST_SMUL;
               end else begin
                  state_ff <= ST_READ;
               end
            end
            ST_SMUL: begin
               state_ff <= ST_SDIV;
            end
            ST_SDIV: begin
               if (div_done) begin
                  if (act_ff == ACT_FADEIN) begin
                     fadec_ff <= div_quot;
                     state_ff <= ST_READ;
                  end else begin
                     newc_ff <= div_quot;
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               unique case (act_ff)
                  ACT_KEEP: begin
                     newc_ff <= keep_col;
                     state_ff <= ST_EMIT;
                  end
                  ACT_FADEIN: begin
                     newc_ff <= fadec_ff;
                     state_ff <= ST_EMIT;
                  end
                  ACT_ON: begin
                     lfsr_ff <= lfsr_next;
                     state_ff <= ST_ON2;
                  end
                  ACT_FADEOUT: begin
                     if (fo_wait) begin
                        all_dark_ff <= 1'b0;
                        newc_ff <= keep_col;
                        state_ff <= ST_EMIT;
                     end else if (fo_dark) begin
                        newc_ff <= '0;
                        state_ff <= ST_EMIT;
                     end else begin
                        all_dark_ff <= 1'b0;
                        num_ff <= MsW'(rd_per_ff - elapsed[SpanW-1:0]);
                        den_ff <= MsW'(rd_per_ff);
                        state_ff <= ST_SMUL;
                     end
                  end
                  default: ;
               endcase
            end
            ST_ON2: begin
               dly_ff <= span_now;
               lfsr_ff <= lfsr_next;
               state_ff <= ST_ON3;
            end
            ST_ON3: begin
               newc_ff <= color_ff;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_load) begin
                  rsp_idx_ff <= idx_ff;
                  rsp_col_ff <= newc_ff;
                  rsp_last_ff <= is_last;
                  if (is_last) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_FINISH: begin
               if (act_ff == ACT_FADEOUT && all_dark_ff) begin
                  phase_ff <= PH_OFF;
                  timer_ff <= '0;
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_led_index = rsp_idx_ff;
   assign rsp_red = rsp_col_ff[0];
   assign rsp_green = rsp_col_ff[1];
   assign rsp_blue = rsp_col_ff[2];
   assign rsp_last_led = rsp_last_ff;

endmodule

### rtl/core/led_sparkle_fade_sequencer.sv
`timescale 1ns / 1ps
// LED sparkle-fade sequencer, top level: one frame tick in (req_frame_ms, the
// milliseconds since the last tick), one colour transfer out per active LED,
// in index order, with rsp_last_led on the final one. Each tick advances a
// saturating phase timer and steps an off / fade-in / on / fade-out cycle.
// A tick runs a set-up (which divides out the common fade-in colour when
// fading in), then walks the active LEDs one at a time over single-port
// stores: colours are held or ramped, each LED's random delay and period
// are drawn in the on tick, and in fade-out each fading LED waits on the
// shared 8-step three-lane divider. A two-entry queue takes ticks while
// the back end is busy; results leave through a registered output, and a
// stalled consumer holds the back end, so the queue fills and stalls input.
// Configuration registers are to be written over csr_* (always ready) while
// the block is idle; the block itself does not enforce this. A seed write
// reloads the generator through a registered strobe.
// Depends on lsfs_pkg, lsfs_front, lsfs_back (and lsfs_div).
module led_sparkle_fade_sequencer import lsfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FrameW-1:0]  req_frame_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [LedIdxW-1:0] rsp_led_index,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic               rsp_last_led,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   // raw register file
   logic [MsW-1:0] off_time_ff;
   logic [MsW-1:0] fade_in_ff;
   logic [MsW-1:0] fade_out_ff;
   logic [6:0] bright_ff;
   logic [23:0] user_color_ff;
   logic random_en_ff;
   logic [6:0] active_ff;
   logic [31:0] seed_ff;
   logic seed_load_ff;

   cfg_type cfg;
   logic q_valid;
   logic [FrameW-1:0] q_frame_ms;
   logic q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_time_ff <= 16'd1000;
         fade_in_ff <= 16'd1000;
         fade_out_ff <= 16'd2000;
         bright_ff <= 7'd100;
         user_color_ff <= 24'hFF_FFFF;
         random_en_ff <= 1'b0;
         active_ff <= 7'd64;
         seed_ff <= 32'd1;
         seed_load_ff <= 1'b0;
      end else begin
         seed_load_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (reg_idx_type'(csr_index))
               REG_OFF_TIME:    off_time_ff <= csr_data[MsW-1:0];
               REG_FADE_IN:     fade_in_ff <= csr_data[MsW-1:0];
               REG_FADE_OUT:    fade_out_ff <= csr_data[MsW-1:0];
               REG_BRIGHTNESS:  bright_ff <= csr_data[6:0];
               REG_USER_COLOR:  user_color_ff <= csr_data[23:0];
               REG_RANDOM_EN:   random_en_ff <= csr_data[0];
               REG_ACTIVE_LEDS: active_ff <= csr_data[6:0];
               REG_SEED: begin
                  seed_ff <= csr_data;
                  seed_load_ff <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // brightness above 100 acts as 100; LED count limited to 1..MaxLeds
   always_comb begin
      cfg.off_time = off_time_ff;
      cfg.fade_in = fade_in_ff;
      cfg.fade_out = fade_out_ff;
      cfg.bright = (bright_ff > PctFull) ? PctFull : bright_ff;
      cfg.user_color = user_color_ff;
      cfg.random_en = random_en_ff;
      if (active_ff == '0) begin
         cfg.led_count = LedCntW'(1);
      end else if (32'(active_ff) > MaxLeds) begin
         cfg.led_count = LedCntW'(MaxLeds);
      end else begin
         cfg.led_count = LedCntW'(active_ff);
      end
   end

   lsfs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_frame_ms (req_frame_ms),
      .q_valid      (q_valid),
      .q_frame_ms   (q_frame_ms),
      .q_pop        (q_pop)
   );

   lsfs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .seed          (seed_ff),
      .seed_load     (seed_load_ff),
      .q_valid       (q_valid),
      .q_frame_ms    (q_frame_ms),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_led_index (rsp_led_index),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_last_led  (rsp_last_led)
   );

`ifndef SYNTH
   // the final transfer of a tick carries the last active index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_led |-> ({1'b0, rsp_led_index} == cfg.led_count - 1'b1))
      else $error("last_led on wrong LED index");

   // every other transfer sits below the last active index
   a_inner_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_led |-> ({1'b0, rsp_led_index} < cfg.led_count - 1'b1))
      else $error("LED index beyond active count");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_sparkle_fade_sequencer: frame ticks in,
// per-LED colour transfers out, compared against an in-bench colour predictor.
// Depends on lsfs_pkg and the sequencer RTL.
module tb;
   import lsfs_pkg::*;

   typedef enum logic [1:0] {PH_OFF, PH_FADE_IN, PH_ON, PH_FADE_OUT} phase_type;

   typedef struct {
      logic [5:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_led;
   } led_colour_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [9:0]        req_frame_ms;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [5:0]        rsp_led_index;
   logic [7:0]        rsp_red;
   logic [7:0]        rsp_green;
   logic [7:0]        rsp_blue;
   logic              rsp_last_led;
   logic              csr_valid;
   logic              csr_ready;
   logic [2:0]        csr_index;
   logic [31:0]       csr_data;

   led_sparkle_fade_sequencer u_dut (.*);

   // 8 ns clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ---------------------------------------------------------------------
   // Colour predictor: own copy of registers and sequencer state
   // ---------------------------------------------------------------------
   logic [15:0] p_off_time, p_fade_in, p_fade_out;
   logic [6:0]  p_bright, p_active;
   logic [23:0] p_user_colour;
   logic        p_random_en;

   phase_type   p_phase;
   logic [16:0] p_timer;
   logic [23:0] p_cycle_colour;
   logic [14:0] p_delay [64];
   logic [14:0] p_period [64];
   logic [23:0] p_colour [64];
   logic [31:0] p_lfsr;
   int          drawn_leds;     // highest LED count whose timing has been drawn

   led_colour_type colour_q[$];  // expected colour transfers, oldest first

   int  errors = 0;
   int  ticks_sent = 0;
   int  colours_checked = 0;
   int  fades_done = 0;
   bit  quiet = 0;               // no idling on either side
   int  hold_left = 0;           // long receiver hold-off, in cycles

   function automatic logic [31:0] next_random();
      logic [31:0] r;
      r = p_lfsr >> 1;
      if (p_lfsr[0]) begin
         r = r ^ 32'h8020_0003;
      end
      p_lfsr = r;
      return r;
   endfunction

   function automatic logic [14:0] random_span();
      longint unsigned r;
      r = next_random();
      r = (r * p_fade_out) >> 33;
      return r[14:0];
   endfunction

   function automatic logic [23:0] scaled(logic [23:0] c, longint unsigned num,
                                          longint unsigned den);
      longint unsigned b, s;
      logic [23:0] o;
      b = (p_bright > 100) ? 100 : p_bright;
      o = '0;
      for (int k = 0; k < 3; k++) begin
         s = c[8*k +: 8];
         s = s * b / 100;
         s = s * num / den;
         o[8*k +: 8] = s[7:0];
      end
      return o;
   endfunction

   function automatic int led_count();
      if (p_active < 1) return 1;
      if (p_active > 64) return 64;
      return p_active;
   endfunction

   task automatic colours_reset();
      p_off_time = 1000; p_fade_in = 1000; p_fade_out = 2000; p_bright = 100;
      p_user_colour = 24'hFFFFFF; p_random_en = 0; p_active = 64;
      p_phase = PH_OFF; p_timer = 0; p_cycle_colour = 0;
      for (int i = 0; i < 64; i++) begin
         p_delay[i] = 0; p_period[i] = 0; p_colour[i] = 0;
      end
      p_lfsr = 1;
      drawn_leds = 0;
   endtask

   task automatic predict_reg(reg_idx_type idx, logic [31:0] v);
      case (idx)
         REG_OFF_TIME:    p_off_time = v[15:0];
         REG_FADE_IN:     p_fade_in = v[15:0];
         REG_FADE_OUT:    p_fade_out = v[15:0];
         REG_BRIGHTNESS:  p_bright = v[6:0];
         REG_USER_COLOR:  p_user_colour = v[23:0];
         REG_RANDOM_EN:   p_random_en = v[0];
         REG_ACTIVE_LEDS: p_active = v[6:0];
         REG_SEED: begin
            p_lfsr = (v == 0) ? 32'd1 : v;
         end
         default: ;
      endcase
   endtask

   // One frame tick: advance the cycle, queue a colour for every active LED.
   task automatic predict_tick(logic [9:0] frame);
      int n;
      int unsigned t;
      bit done;
      logic [31:0] e;
      logic [31:0] rnd;
      led_colour_type c;
      n = led_count();
      t = p_timer + frame;
      p_timer = (t > 131071) ? 17'h1FFFF : t[16:0];
      case (p_phase)
         PH_OFF: begin
            if (p_timer > p_off_time) begin
               p_phase = PH_FADE_IN;
               p_timer = 0;
               if (p_random_en) begin
                  rnd = next_random();
                  p_cycle_colour = rnd[23:0];
               end else begin
                  p_cycle_colour = p_user_colour;
               end
            end
         end
         PH_FADE_IN: begin
            if (p_timer > p_fade_in) begin
               p_phase = PH_ON;
            end else begin
               for (int i = 0; i < n; i++) begin
                  p_colour[i] = (p_fade_in != 0) ? scaled(p_cycle_colour, p_timer, p_fade_in)
                                                 : scaled(p_cycle_colour, 1, 1);
               end
            end
         end
         PH_ON: begin
            for (int i = 0; i < n; i++) begin
               p_delay[i] = random_span();
               p_colour[i] = p_cycle_colour;
               p_period[i] = random_span();
            end
            if (n > drawn_leds) drawn_leds = n;
            p_phase = PH_FADE_OUT;
            p_timer = 0;
         end
         default: begin
            done = 1;
            for (int i = 0; i < n; i++) begin
               if (p_timer < p_delay[i]) begin
                  done = 0;
               end else begin
                  e = p_timer - p_delay[i];
                  if (p_period[i] == 0 || e > p_period[i]) begin
                     p_colour[i] = 0;
                  end else begin
                     done = 0;
                     p_colour[i] = scaled(p_cycle_colour, p_period[i] - e, p_period[i]);
                  end
               end
            end
            if (done) begin
               p_phase = PH_OFF;
               p_timer = 0;
               fades_done++;
            end
         end
      endcase
      for (int i = 0; i < n; i++) begin
         c.led_index = i[5:0];
         c.red = p_colour[i][7:0];
         c.green = p_colour[i][15:8];
         c.blue = p_colour[i][23:16];
         c.last_led = (i + 1 == n);
         colour_q = {colour_q, c};
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, plus an occasional long hold-off
   // ---------------------------------------------------------------------
   int stall_burst = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_burst > 0) begin
         stall_burst <= stall_burst - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_burst <= $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Each colour transfer against the oldest expectation
   always @(posedge clock) begin
      led_colour_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (colour_q.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, got led %0d", $time,
                     rsp_led_index);
            errors++;
         end else begin
            w = colour_q.pop_front();
            check_field("led_index", w.led_index, rsp_led_index);
            check_field("red", w.red, rsp_red);
            check_field("green", w.green, rsp_green);
            check_field("blue", w.blue, rsp_blue);
            check_field("last_led", w.last_led, rsp_last_led);
            colours_checked++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender and register tasks
   // ---------------------------------------------------------------------
   task automatic send_tick(logic [9:0] frame);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frame_ms <= frame;
      do @(posedge clock); while (req_stall);
      predict_tick(frame);
      ticks_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (colour_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Writes only once the block has gone quiet.
   task automatic write_reg(reg_idx_type idx, logic [31:0] v);
      drain();
      // never let the LED count grow past drawn timing while fading out
      if (idx == REG_ACTIVE_LEDS && p_phase == PH_FADE_OUT) begin
         if (((v[6:0] < 1) ? 1 : (v[6:0] > 64) ? 64 : v[6:0]) > drawn_leds) begin
            v = 32'(drawn_leds);
         end
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      predict_reg(idx, v);
   endtask

   task automatic random_setup(bit wide);
      write_reg(REG_OFF_TIME, $urandom_range(0, 300));
      write_reg(REG_FADE_IN, $urandom_range(1, 300));
      write_reg(REG_FADE_OUT, $urandom_range(0, 700));
      write_reg(REG_BRIGHTNESS, $urandom_range(0, 127));
      write_reg(REG_USER_COLOR, $urandom());
      write_reg(REG_RANDOM_EN, $urandom_range(0, 1));
      write_reg(REG_SEED, ($urandom_range(0, 9) == 0) ? 0 : $urandom());
      write_reg(REG_ACTIVE_LEDS, wide ? $urandom_range(0, 127) : $urandom_range(1, 12));
   endtask

   function automatic logic [9:0] random_frame();
      return ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 63))
                                        : 10'($urandom_range(0, 1023));
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_reset_cycle();
      // reset values: off 1000, fade-in 1000, 64 white LEDs
      send_tick(10'd1023);   // off ends, cycle colour picked
      send_tick(10'd0);      // fade-in at timer zero: black
      send_tick(10'd500);
      send_tick(10'd500);    // timer equals fade-in: full colour
      send_tick(10'd1);      // into on
      send_tick(10'd0);      // on: raw colour, timing drawn
      send_tick(10'd0);      // LEDs still before their delays
      send_tick(10'd1023);
      send_tick(10'd1023);
      send_tick(10'd1023);   // off ends again, new cycle colour picked
   endtask

   task automatic test_edges();
      write_reg(REG_FADE_IN, 0);         // zero-length fade-in
      write_reg(REG_OFF_TIME, 0);
      write_reg(REG_BRIGHTNESS, 127);    // above hundred
      write_reg(REG_ACTIVE_LEDS, 0);     // clamps to one
      write_reg(REG_SEED, 0);            // loads as one
      write_reg(REG_RANDOM_EN, 1);
      write_reg(REG_FADE_OUT, 1);        // zero periods
      send_tick(10'd1);
      send_tick(10'd0);
      send_tick(10'd5);
      send_tick(10'd0);
      send_tick(10'd0);
      write_reg(REG_ACTIVE_LEDS, 127);   // clamps to 64
      write_reg(REG_FADE_OUT, 16'hFFFF);
      write_reg(REG_OFF_TIME, 16'hFFFF);
      write_reg(REG_FADE_IN, 16'hFFFF);
      write_reg(REG_USER_COLOR, 24'hFFFFFF);
      write_reg(REG_SEED, 32'hFFFFFFFF);
      send_tick(10'd1023);
      send_tick(10'd1023);
      write_reg(REG_OFF_TIME, 1);
      write_reg(REG_FADE_IN, 1);
      write_reg(REG_BRIGHTNESS, 0);
      send_tick(10'd0);
      send_tick(10'd1);
      send_tick(10'd1023);
      send_tick(10'd1023);
   endtask

   task automatic test_random(int rounds, int per_round);
      for (int r = 0; r < rounds; r++) begin
         random_setup(r % 4 == 3);
         for (int k = 0; k < per_round; k++) begin
            send_tick(random_frame());
         end
      end
   endtask

   task automatic test_backpressure();
      write_reg(REG_ACTIVE_LEDS, 64);
      hold_left = 4000;
      // keep offering while the receiver is held off; the input must stall
      for (int k = 0; k < 6; k++) begin
         send_tick(random_frame());
      end
      drain();               // sender waits for every colour
      for (int k = 0; k < 4; k++) begin
         send_tick(random_frame());
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_frame_ms <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_OFF_TIME;
      csr_data <= '0;
      colours_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_cycle();
      test_edges();
      test_backpressure();
      test_random(8, 47);
      quiet = 1;
      test_random(1, 47);

      drain();
      $display("tb: %0d frame ticks, %0d LED colours checked, %0d fade cycles completed",
               ticks_sent, colours_checked, fades_done);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("tb: timeout");
      $display("tb: done, errors");
      $finish;
   end

endmodule

### led_sparkle_fade_sequencer.f
rtl/core/lsfs_pkg.sv
rtl/core/lsfs_front.sv
rtl/core/lsfs_div.sv
rtl/core/lsfs_back.sv
rtl/core/led_sparkle_fade_sequencer.sv
tb/sv/tb.sv
